[hw/rtl/lcm_pkg.sv]
// shared types and constants for the lcm_of_two_integers block
package lcm_pkg;

   // operand width in bits, 4 to 32
   localparam int WIDTH = 32;
   // width of the product and of the shared adder
   localparam int DW = 2 * WIDTH;
   // step counter and power-of-two count width
   localparam int CNT_W = $clog2(WIDTH);

   // input transaction
   typedef struct packed {
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [63:0] multiple;
      logic [31:0] divisor;
      logic        zero_operand;
   } rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

   // request to the shared add/subtract unit
   typedef struct packed {
      logic          sub;
      logic [DW-1:0] lhs;
      logic [DW-1:0] rhs;
   } alu_req_type;

   // answer of the shared add/subtract unit
   typedef struct packed {
      logic [DW-1:0] sum;
      logic          carry;
      logic          zero;
   } alu_rsp_type;

endpackage

[hw/rtl/lcm_addsub.sv]
// shared add/subtract unit: one wide adder with carry/borrow and zero flag
module lcm_addsub (
   input  lcm_pkg::alu_req_type alu_req,
   output lcm_pkg::alu_rsp_type alu_rsp
);

   logic [lcm_pkg::DW:0] rhs_ext;
   logic [lcm_pkg::DW:0] total;

   // invert and add one to subtract; top bit is carry on add, borrow on subtract
   assign rhs_ext = {1'b0, alu_req.rhs} ^ {(lcm_pkg::DW + 1){alu_req.sub}};
   assign total   = {1'b0, alu_req.lhs} + rhs_ext + {{lcm_pkg::DW{1'b0}}, alu_req.sub};

   assign alu_rsp.sum   = total[lcm_pkg::DW-1:0];
   assign alu_rsp.carry = total[lcm_pkg::DW];
   assign alu_rsp.zero  = (total[lcm_pkg::DW-1:0] == '0);

endmodule

[hw/rtl/lcm_of_two_integers.sv]
// top level: sequencer and registers around one shared adder for gcd and lcm
//
// Least common multiple and greatest common divisor of two unsigned WIDTH-bit
// operands (bits above WIDTH ignored). Pulse start while busy is low to hand in
// a transaction; busy stays high until the result has been shown. The result
// is on rsp_data for exactly one cycle with rsp_strobe high and cannot be held
// off, so the receiver must take it then. A zero operand gives zero_operand = 1
// with both values zero, in the cycle right after start is taken. Otherwise the
// gcd is found by binary (halving and subtracting) steps, one per cycle, then
// the quotient a / gcd by WIDTH restoring-division steps and the product
// (a / gcd) * b by WIDTH shift-and-add steps, all through the one shared
// 2*WIDTH-bit adder. The number of gcd steps depends on the operands.
module lcm_of_two_integers (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  lcm_pkg::req_type req_data,
   output logic             rsp_strobe,
   output lcm_pkg::rsp_type rsp_data
);

   localparam int W = lcm_pkg::WIDTH;
   localparam int DW = lcm_pkg::DW;
   localparam int CW = lcm_pkg::CNT_W;

   lcm_pkg::state_type state_ff, state_in;

   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  g_ff, g_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  q_ff, q_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          err_ff, err_in;

   logic          accept;
   logic [W-1:0]  op_a;
   logic [W-1:0]  op_b;
   logic          zero_in;
   logic          gcd_done;
   logic          last_step;
   logic [W:0]    rem_shift;

   lcm_pkg::alu_req_type alu_req;
   lcm_pkg::alu_rsp_type alu_rsp;

   // shared adder
   lcm_addsub u_addsub (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign op_a      = req_data.operand_a[W-1:0];
   assign op_b      = req_data.operand_b[W-1:0];
   assign zero_in   = (op_a == '0) || (op_b == '0);
   assign accept    = start && (state_ff == lcm_pkg::ST_IDLE);
   assign gcd_done  = x_ff[0] && y_ff[0] && !alu_rsp.carry && alu_rsp.zero;
   assign last_step = (cnt_ff == '0);
   assign rem_shift = {rem_ff, q_ff[W-1]};

   // operand selection for the shared adder
   always_comb begin
      alu_req.sub = 1'b1;
      alu_req.lhs = '0;
      alu_req.rhs = '0;
      unique case (state_ff)
         lcm_pkg::ST_GCD: begin
            alu_req.lhs = DW'(x_ff);
            alu_req.rhs = DW'(y_ff);
         end
         lcm_pkg::ST_DIV: begin
            alu_req.lhs = DW'(rem_shift);
            alu_req.rhs = DW'(g_ff);
         end
         lcm_pkg::ST_MUL: begin
            alu_req.sub = 1'b0;
            alu_req.lhs = {acc_ff[DW-2:0], 1'b0};
            alu_req.rhs = q_ff[W-1] ? DW'(b_ff) : '0;
         end
         default: begin
            alu_req.sub = 1'b1;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lcm_pkg::ST_IDLE: begin
            if (start) begin
               state_in = zero_in ? lcm_pkg::ST_DONE : lcm_pkg::ST_GCD;
            end
         end
         lcm_pkg::ST_GCD: begin
            if (gcd_done) begin
               state_in = lcm_pkg::ST_DIV;
            end
         end
         lcm_pkg::ST_DIV: begin
            if (last_step) begin
               state_in = lcm_pkg::ST_MUL;
            end
         end
         lcm_pkg::ST_MUL: begin
            if (last_step) begin
               state_in = lcm_pkg::ST_DONE;
            end
         end
         lcm_pkg::ST_DONE: begin
            state_in = lcm_pkg::ST_IDLE;
         end
         default: begin
            state_in = lcm_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy                  = (state_ff != lcm_pkg::ST_IDLE);
      rsp_strobe            = (state_ff == lcm_pkg::ST_DONE);
      rsp_data.multiple     = 64'(acc_ff);
      rsp_data.divisor      = 32'(g_ff);
      rsp_data.zero_operand = err_ff;
   end

   // datapath next values
   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      b_in   = b_ff;
      g_in   = g_ff;
      rem_in = rem_ff;
      q_in   = q_ff;
      acc_in = acc_ff;
      k_in   = k_ff;
      cnt_in = cnt_ff;
      err_in = err_ff;
      unique case (state_ff)
         lcm_pkg::ST_IDLE: begin
            if (accept) begin
               x_in   = op_a;
               y_in   = op_b;
               b_in   = op_b;
               q_in   = op_a;
               rem_in = '0;
               k_in   = '0;
               err_in = zero_in;
               acc_in = '0;
               g_in   = '0;
            end
         end
         lcm_pkg::ST_GCD: begin
            // binary gcd: strip common twos, halve even sides, subtract odd pairs
            if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + CW'(1);
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (alu_rsp.carry) begin
               x_in = y_ff;
               y_in = x_ff;
            end else if (alu_rsp.zero) begin
               g_in   = x_ff << k_ff;
               cnt_in = CW'(W - 1);
            end else begin
               x_in = alu_rsp.sum[W:1];
            end
         end
         lcm_pkg::ST_DIV: begin
            // restoring division of a by the gcd, quotient shifts into q
            if (alu_rsp.carry) begin
               rem_in = rem_shift[W-1:0];
            end else begin
               rem_in = alu_rsp.sum[W-1:0];
            end
            q_in   = {q_ff[W-2:0], !alu_rsp.carry};
            cnt_in = cnt_ff - CW'(1);
            if (last_step) begin
               cnt_in = CW'(W - 1);
               acc_in = '0;
            end
         end
         lcm_pkg::ST_MUL: begin
            // shift-and-add product of quotient and b, msb first
            acc_in = alu_rsp.sum;
            q_in   = {q_ff[W-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
         end
         default: begin
            err_in = err_ff;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      b_ff   <= b_in;
      g_ff   <= g_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      acc_ff <= acc_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
      err_ff <= err_in;
   end

`ifndef SYNTHESIS
   // an accepted transaction keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after accepting a transaction");

   // gcd iteration never sees a zero operand
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcm_pkg::ST_GCD) |-> (x_ff != '0) && (y_ff != '0))
      else $error("zero operand inside gcd iteration");

   // a valid result carries a nonzero gcd and a nonzero multiple
   a_result_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.zero_operand) |->
         (rsp_data.divisor != '0) && (rsp_data.multiple != '0))
      else $error("valid result with zero gcd or multiple");

   // an error result has both values cleared
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.zero_operand) |->
         (rsp_data.divisor == '0) && (rsp_data.multiple == '0))
      else $error("error result with nonzero values");

   // the division leaves no remainder, since the gcd divides a
   a_exact_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lcm_pkg::ST_MUL) && ($past(state_ff) == lcm_pkg::ST_DIV)
         |-> (rem_ff == '0))
      else $error("remainder left after dividing by the gcd");
`endif

endmodule
